// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When cond holds at one edge, res must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("assertion failed");

`endif

// ===== rtl/spft_pkg.sv =====
// Package of the SPI packet framer: request codes, item types, default sizes.
// No dependencies; used by every module of the framer.
`default_nettype none

package spft_pkg;

  localparam int unsigned PacketBytesDef = 8;
  localparam int unsigned QueueDepthDef  = 4;

  typedef enum logic [2:0] {
    ReqSelect  = 3'd0,
    ReqRxByte  = 3'd1,
    ReqEnqueue = 3'd2,
    ReqPull    = 3'd3,
    ReqPop     = 3'd4
  } req_e;

  // One request as held in the input register.
  typedef struct packed {
    logic [2:0]  req_type;
    logic        select_low;
    logic [7:0]  rx_byte;
    logic [63:0] tx_packet;
  } in_item_t;

  // Write request from the engine to the transmit ring.
  typedef struct packed {
    logic        we;
    logic [63:0] data;
  } ring_wr_t;

endpackage

`default_nettype wire

// ===== rtl/spi_packet_framer_tx_queue_core.sv =====
// Top level of the SPI slave packet framer with its transmit ring.
// Depends on spft_pkg, assert_macros.svh and spft_engine.
`default_nettype none
`include "assert_macros.svh"

// Usage
// A request is a command transfer: drive req_type_i and the payload ports and
// raise start for one cycle. The transfer takes place at a rising edge where
// start is high and busy is low. Busy never rises, so a new request can be
// issued in every cycle, one request per clock sustained.
// Each request yields exactly one result transfer. The result appears on the
// result ports after the input and result registers and is taken at the next
// rising edge. While the request sits in the input register the engine updates
// the framer state, and the result register loads at the end of that cycle.
// done_o is high for exactly the following cycle and the result ports are
// meaningful only then. The receiver cannot stall, so results are never held
// back and never overwritten before their cycle. The interrupt polarity
// register is written with cfg_we_i and cfg_wdata_i while no request is in
// flight, a user rule the block does not enforce; it takes effect on the next
// result. Reset clears the ring pointers, fill count, receive frame state and
// the interrupt, and sets the polarity to active high. Ring and receive buffer
// contents are undefined until written; no clearing pass is needed. rx_ready_o,
// irq_pin_o and tx_queued_o report the state after the request.

module spi_packet_framer_tx_queue_core #(
  parameter int unsigned PacketBytes = spft_pkg::PacketBytesDef,
  parameter int unsigned QueueDepth  = spft_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic        select_low_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [63:0] tx_packet_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  output logic             done_o,
  output logic             accepted_o,
  output logic [7:0]       tx_byte_o,
  output logic [63:0]      rx_packet_o,
  output logic             rx_ready_o,
  output logic             irq_pin_o,
  output logic [2:0]       tx_queued_o
);

  // Input register: the request is captured first so the engine sees a
  // stable command while it updates the state.
  logic               in_valid_q;
  spft_pkg::in_item_t in_q;
  logic               irq_high_q;

  // The engine finishes a request every cycle, so the command port is
  // always open.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      irq_high_q <= 1'b1;
    end else begin
      in_valid_q <= start && !busy;
      if (cfg_we_i) begin
        irq_high_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q.req_type   <= req_type_i;
      in_q.select_low <= select_low_i;
      in_q.rx_byte    <= rx_byte_i;
      in_q.tx_packet  <= tx_packet_i;
    end
  end

  spft_engine #(
    .PacketBytes(PacketBytes),
    .QueueDepth (QueueDepth)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_q),
    .in_i             (in_q),
    .irq_active_high_i(irq_high_q),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .tx_byte_o        (tx_byte_o),
    .rx_packet_o      (rx_packet_o),
    .rx_ready_o       (rx_ready_o),
    .irq_pin_o        (irq_pin_o),
    .tx_queued_o      (tx_queued_o)
  );

  // Every accepted request raises in_valid_q and, after it, done_o.
  `ASSERT_NEXT(a_req_gives_done, clk_i, rst_ni, start && !busy, in_valid_q)
  `ASSERT_NEXT(a_stage_gives_done, clk_i, rst_ni, in_valid_q, done_o)
  `ASSERT_NEXT(a_no_spurious_done, clk_i, rst_ni, !in_valid_q, !done_o)

endmodule

`default_nettype wire

// ===== rtl/spft_ring.sv =====
// Transmit ring storage: one write port, one registered read port with bypass.
// Depends on spft_pkg for the write request type.
`default_nettype none

module spft_ring #(
  parameter int unsigned QueueDepth = spft_pkg::QueueDepthDef,
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  wire logic              clk_i,
  input  wire spft_pkg::ring_wr_t wr_i,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output logic [63:0]            rd_data_o
);

  logic [63:0] mem [QueueDepth];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_addr_i] <= wr_i.data;
    end
  end

  // A write to the entry being read this cycle is forwarded so the next
  // read sees the new packet.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/spft_engine.sv =====
// Framer state and request processing between the input and result registers.
// Depends on spft_pkg, assert_macros.svh and the ring module spft_ring.
`default_nettype none
`include "assert_macros.svh"

module spft_engine #(
  parameter int unsigned PacketBytes = spft_pkg::PacketBytesDef,
  parameter int unsigned QueueDepth  = spft_pkg::QueueDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire spft_pkg::in_item_t in_i,
  input  wire logic              irq_active_high_i,
  output logic                   done_o,
  output logic                   accepted_o,
  output logic [7:0]             tx_byte_o,
  output logic [63:0]            rx_packet_o,
  output logic                   rx_ready_o,
  output logic                   irq_pin_o,
  output logic [2:0]             tx_queued_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned PosW = (PacketBytes > 1) ? $clog2(PacketBytes) : 1;
  localparam int unsigned CntW = $clog2(PacketBytes + 1);
  localparam logic [63:0] PktMask =
    (PacketBytes >= 8) ? {64{1'b1}} : ((64'd1 << (8 * PacketBytes)) - 64'd1);
  localparam logic [FillW-1:0] FillMax = FillW'(QueueDepth);
  localparam logic [CntW-1:0] CntMax = CntW'(PacketBytes);
  localparam logic [PosW-1:0] PosLast = PosW'(PacketBytes - 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QueueDepth - 1);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    if (idx == IdxLast) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [63:0]      rx_buf_q, rx_buf_d;
  logic             rx_done_q, rx_done_d;
  logic             was_sel_q, was_sel_d;
  logic             irq_q, irq_d;

  logic             done_q;
  logic             acc_q, acc_d;
  logic [7:0]       tx_byte_q, tx_byte_d;
  logic [63:0]      rx_pkt_q, rx_pkt_d;
  logic             pin_q;
  logic [FillW+2:0] fill_ext;

  spft_pkg::ring_wr_t ring_wr;
  logic [63:0]        ring_rd_data;

  spft_ring #(
    .QueueDepth(QueueDepth)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_i     (ring_wr),
    .wr_addr_i(head_q),
    .rd_addr_i(tail_d),
    .rd_data_o(ring_rd_data)
  );

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    rx_buf_d  = rx_buf_q;
    rx_done_d = rx_done_q;
    was_sel_d = was_sel_q;
    irq_d     = irq_q;
    acc_d     = 1'b0;
    tx_byte_d = 8'd0;
    rx_pkt_d  = 64'd0;
    ring_wr.we   = 1'b0;
    ring_wr.data = in_i.tx_packet & PktMask;

    if (in_valid_i) begin
      unique case (spft_pkg::req_e'(in_i.req_type))
        spft_pkg::ReqSelect: begin
          if (in_i.select_low && !was_sel_q) begin
            cnt_d     = '0;
            rx_done_d = 1'b0;
            was_sel_d = 1'b1;
          end else if (!in_i.select_low && was_sel_q) begin
            rx_done_d = (cnt_q == CntMax);
            cnt_d     = '0;
            was_sel_d = 1'b0;
          end
        end
        spft_pkg::ReqRxByte: begin
          if (was_sel_q && (cnt_q < CntMax)) begin
            rx_buf_d[{cnt_q[PosW-1:0], 3'b000} +: 8] = in_i.rx_byte;
            cnt_d = cnt_q + 1'b1;
          end
        end
        spft_pkg::ReqEnqueue: begin
          if (fill_q < FillMax) begin
            ring_wr.we = 1'b1;
            head_d     = next_idx(head_q);
            fill_d     = fill_q + 1'b1;
            irq_d      = 1'b1;
            acc_d      = 1'b1;
          end
        end
        spft_pkg::ReqPull: begin
          if (fill_q != '0) begin
            tx_byte_d = ring_rd_data[{pos_q, 3'b000} +: 8];
            acc_d     = 1'b1;
            if (pos_q == PosLast) begin
              pos_d  = '0;
              tail_d = next_idx(tail_q);
              fill_d = fill_q - 1'b1;
              if (fill_q == FillW'(1)) begin
                irq_d = 1'b0;
              end
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        spft_pkg::ReqPop: begin
          if (rx_done_q) begin
            rx_pkt_d  = rx_buf_q & PktMask;
            rx_done_d = 1'b0;
            acc_d     = 1'b1;
          end
        end
        default: begin
          // Unknown request codes change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      rx_done_q <= 1'b0;
      was_sel_q <= 1'b0;
      irq_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      rx_done_q <= rx_done_d;
      was_sel_q <= was_sel_d;
      irq_q     <= irq_d;
      done_q    <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_buf_q  <= rx_buf_d;
    acc_q     <= acc_d;
    tx_byte_q <= tx_byte_d;
    rx_pkt_q  <= rx_pkt_d;
    pin_q     <= irq_d ^ ~irq_active_high_i;
  end

  assign fill_ext    = {3'b000, fill_q};
  assign done_o      = done_q;
  assign accepted_o  = acc_q;
  assign tx_byte_o   = tx_byte_q;
  assign rx_packet_o = rx_pkt_q;
  assign rx_ready_o  = rx_done_q;
  assign irq_pin_o   = pin_q;
  assign tx_queued_o = fill_ext[2:0];

  `ASSERT_AT(a_fill_bound, clk_i, rst_ni, fill_q <= FillMax)
  `ASSERT_AT(a_irq_tracks_fill, clk_i, rst_ni, irq_q == (fill_q != '0))
  `ASSERT_AT(a_pos_needs_packet, clk_i, rst_ni, (pos_q == '0) || (fill_q != '0))
  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntMax)

endmodule

`default_nettype wire

// ===== verif/spi_packet_framer_tx_queue_core_tb.sv =====
// Self-checking testbench for spi_packet_framer_tx_queue_core: receive frames, transmit ring,
// packet pops and the interrupt pin, checked against a predictor of the framer.
// Depends on spft_pkg and the framer RTL.

module spi_packet_framer_tx_queue_core_tb;

  localparam int unsigned PktBytes = spft_pkg::PacketBytesDef;
  localparam int unsigned QDepth   = spft_pkg::QueueDepthDef;

  // Bits above the packet length never survive an enqueue or a pop.
  localparam logic [63:0] PktMask =
    (PktBytes >= 8) ? '1 : ((64'd1 << (8 * PktBytes)) - 64'd1);

  // Request codes past the last defined one; the framer must ignore them.
  localparam logic [2:0] ReqUnusedLo = 3'(spft_pkg::ReqPop + 1);
  localparam logic [2:0] ReqUnusedHi = '1;

  // Cycles with no transfer at all before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Random items per configuration phase.
  localparam int unsigned PhaseItems = 232;

  // What one request transfer produces on the result ports.
  typedef struct packed {
    logic        accepted;
    logic [7:0]  tx_byte;
    logic [63:0] rx_packet;
    logic        rx_ready;
    logic        irq_pin;
    logic [2:0]  tx_queued;
  } reply_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic               cfg_we      = 1'b0;
  logic               cfg_wdata   = 1'b0;
  spft_pkg::in_item_t cur_req     = '0;
  logic               done;
  logic               accepted;
  logic [7:0]         tx_byte;
  logic [63:0]        rx_packet;
  logic               rx_ready;
  logic               irq_pin;
  logic [2:0]         tx_queued;

  spi_packet_framer_tx_queue_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type_i   (cur_req.req_type),
    .select_low_i (cur_req.select_low),
    .rx_byte_i    (cur_req.rx_byte),
    .tx_packet_i  (cur_req.tx_packet),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .done_o       (done),
    .accepted_o   (accepted),
    .tx_byte_o    (tx_byte),
    .rx_packet_o  (rx_packet),
    .rx_ready_o   (rx_ready),
    .irq_pin_o    (irq_pin),
    .tx_queued_o  (tx_queued)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Requests waiting to be driven, and the replies the framer still owes us.
  spft_pkg::in_item_t req_backlog[$];
  reply_t      replies_due[$];
  int unsigned items_queued = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 25;
  // Set at each rising edge when the request on the ports was transferred.
  logic        req_taken    = 1'b0;

  // Predicted framer state. The frame buffer starts as zero and the ring is left
  // unset, but the stimulus never reads an entry that was not written first.
  logic [63:0] ring_img [QDepth];
  int unsigned ring_wr_ptr = 0;
  int unsigned ring_rd_ptr = 0;
  int unsigned ring_count  = 0;
  int unsigned pull_pos    = 0;
  logic [63:0] frame_buf   = '0;
  int unsigned frame_len   = 0;
  logic        frame_ready = 1'b0;
  logic        selected    = 1'b0;
  logic        irq_raised  = 1'b0;
  logic        irq_high    = 1'b1;

  // Applies one request to the predicted state and returns the reply that the
  // framer has to give for it. The status outputs show the state afterwards.
  function automatic reply_t framer_reply(spft_pkg::in_item_t it);
    reply_t r;
    r = '0;
    case (it.req_type)
      spft_pkg::ReqSelect: begin
        // Only a change of the sampled level is an edge. A falling select starts
        // a clean frame; a rising one keeps the frame only if it is exactly full.
        if (it.select_low && !selected) begin
          frame_len   = 0;
          frame_ready = 1'b0;
          selected    = 1'b1;
        end else if (!it.select_low && selected) begin
          frame_ready = (frame_len == PktBytes);
          frame_len   = 0;
          selected    = 1'b0;
        end
      end
      spft_pkg::ReqRxByte: begin
        // Bytes outside a frame, or past a full one, are dropped.
        if (selected && frame_len < PktBytes) begin
          frame_buf[8 * frame_len +: 8] = it.rx_byte;
          frame_len++;
        end
      end
      spft_pkg::ReqEnqueue: begin
        if (ring_count < QDepth) begin
          ring_img[ring_wr_ptr] = it.tx_packet & PktMask;
          ring_wr_ptr = (ring_wr_ptr + 1 >= QDepth) ? 0 : ring_wr_ptr + 1;
          ring_count++;
          irq_raised  = 1'b1;
          r.accepted  = 1'b1;
        end
      end
      spft_pkg::ReqPull: begin
        // Byte 0 of the oldest packet goes first; the packet leaves the ring with
        // its last byte, and the interrupt drops once the ring is empty.
        if (ring_count > 0) begin
          r.tx_byte  = ring_img[ring_rd_ptr][8 * pull_pos +: 8];
          r.accepted = 1'b1;
          pull_pos++;
          if (pull_pos >= PktBytes) begin
            pull_pos    = 0;
            ring_rd_ptr = (ring_rd_ptr + 1 >= QDepth) ? 0 : ring_rd_ptr + 1;
            ring_count--;
            if (ring_count == 0) begin
              irq_raised = 1'b0;
            end
          end
        end
      end
      spft_pkg::ReqPop: begin
        if (frame_ready) begin
          r.rx_packet = frame_buf & PktMask;
          frame_ready = 1'b0;
          r.accepted  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.rx_ready  = frame_ready;
    r.irq_pin   = irq_raised ^ ~irq_high;
    r.tx_queued = 3'(ring_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: checks each result transfer against the oldest prediction, then predicts
  // the reply of a request transferred at this same edge. A reply lags its request
  // by the input and result registers, so the two never refer to one item.
  always @(posedge clk) begin
    reply_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      quiet_cycles++;
      if (done) begin
        quiet_cycles = 0;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual accepted %0b tx_byte %0h",
                   $time, accepted, tx_byte);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(accepted));
          check_field("tx_byte", 64'(want.tx_byte), 64'(tx_byte));
          check_field("rx_packet", want.rx_packet, rx_packet);
          check_field("rx_ready", 64'(want.rx_ready), 64'(rx_ready));
          check_field("irq_pin", 64'(want.irq_pin), 64'(irq_pin));
          check_field("tx_queued", 64'(want.tx_queued), 64'(tx_queued));
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        req_taken    = 1'b1;
        replies_due.push_back(framer_reply(cur_req));
      end
    end
  end

  // Driver: on the falling edge, once the last request was transferred (or none
  // was offered), either presents the next backlog item or idles.
  always @(negedge clk) begin
    if (rst_n && (!start || req_taken)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cur_req <= req_backlog.pop_front();
        start   <= 1'b1;
      end else begin
        start   <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if transfers stop for too long.
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic queue_req(logic [2:0] code, logic sel, logic [7:0] b, logic [63:0] pkt);
    spft_pkg::in_item_t it;
    it.req_type   = code;
    it.select_low = sel;
    it.rx_byte    = b;
    it.tx_packet  = pkt;
    req_backlog.push_back(it);
    items_queued++;
  endtask

  // Waits until every request is transferred and every reply checked, then
  // waits on so that a stray result would still be seen.
  task automatic drain();
    while (req_backlog.size() != 0 || start || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned pick;
    int unsigned n;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the polarity at its reset value (active high).
    // Pull and pop with nothing there, a byte while deselected, unknown codes.
    queue_req(spft_pkg::ReqPull, 1'b0, 8'h00, 64'h0);
    queue_req(spft_pkg::ReqPop, 1'b0, 8'h00, 64'h0);
    queue_req(spft_pkg::ReqRxByte, 1'b0, 8'hFF, 64'h0);
    queue_req(ReqUnusedLo, 1'b1, 8'hFF, '1);
    queue_req(ReqUnusedHi, 1'b1, 8'hFF, '1);
    // A full frame with a repeated select level, an extra byte past the frame,
    // then a repeated deselect and a pop of the finished packet.
    queue_req(spft_pkg::ReqSelect, 1'b1, 8'h00, 64'h0);
    queue_req(spft_pkg::ReqSelect, 1'b1, 8'h00, 64'h0);
    for (int i = 0; i < PktBytes; i++) begin
      queue_req(spft_pkg::ReqRxByte, 1'b1,
                (i == 0) ? 8'h00 : (i == PktBytes - 1) ? 8'hFF : 8'($urandom), 64'h0);
    end
    queue_req(spft_pkg::ReqRxByte, 1'b1, 8'hA5, 64'h0);
    queue_req(spft_pkg::ReqSelect, 1'b0, 8'h00, 64'h0);
    queue_req(spft_pkg::ReqSelect, 1'b0, 8'h00, 64'h0);
    queue_req(spft_pkg::ReqPop, 1'b0, 8'h00, 64'h0);
    // Fill the ring with the extreme packets, and one more that is refused.
    queue_req(spft_pkg::ReqEnqueue, 1'b0, 8'h00, '1);
    queue_req(spft_pkg::ReqEnqueue, 1'b0, 8'h00, 64'h0);
    for (int i = 0; i <= QDepth - 2; i++) begin
      queue_req(spft_pkg::ReqEnqueue, 1'b0, 8'h00, {$urandom, $urandom});
    end

    // Random part in four phases: the polarity changes between phases while the
    // framer is idle, and the third phase runs with no idle cycles at all.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ph[0] ? 1'b0 : 1'b1;
        irq_high   = ph[0] ? 1'b0 : 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
      end
      gap_pct   = (ph == 2) ? 0 : 25;
      phase_end = items_queued + PhaseItems;
      while (items_queued < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // A receive frame, mostly of the right length, sometimes short or long.
          n = ($urandom_range(99) < 70) ? PktBytes : $urandom_range(PktBytes + 2);
          queue_req(spft_pkg::ReqSelect, 1'b1, 8'($urandom), {$urandom, $urandom});
          if ($urandom_range(9) == 0) begin
            queue_req(spft_pkg::ReqSelect, 1'b1, 8'($urandom), {$urandom, $urandom});
          end
          for (int i = 0; i < n; i++) begin
            queue_req(spft_pkg::ReqRxByte, 1'($urandom), 8'($urandom),
                      {$urandom, $urandom});
          end
          queue_req(spft_pkg::ReqSelect, 1'b0, 8'($urandom), {$urandom, $urandom});
          if ($urandom_range(99) < 80) begin
            queue_req(spft_pkg::ReqPop, 1'($urandom), 8'($urandom),
                      {$urandom, $urandom});
          end
        end else if (pick < 55) begin
          queue_req(spft_pkg::ReqEnqueue, 1'($urandom), 8'($urandom),
                    {$urandom, $urandom});
        end else if (pick < 80) begin
          // A burst of pulls, often crossing a packet boundary.
          n = $urandom_range(2 * PktBytes, 1);
          for (int i = 0; i < n; i++) begin
            queue_req(spft_pkg::ReqPull, 1'($urandom), 8'($urandom),
                      {$urandom, $urandom});
          end
        end else begin
          // Noise: any code, including the unknown ones, with random payload.
          queue_req(3'($urandom_range(ReqUnusedHi)), 1'($urandom), 8'($urandom),
                    {$urandom, $urandom});
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== spi_packet_framer_tx_queue_core.f =====
+incdir+rtl
rtl/spft_pkg.sv
rtl/spft_ring.sv
rtl/spft_engine.sv
rtl/spi_packet_framer_tx_queue_core.sv
verif/spi_packet_framer_tx_queue_core_tb.sv
